>>> rtl/core/aslca_pkg.sv
// Package with the constants and types of the converter scan, limit check and averager.
`timescale 1ns / 1ps

package aslca_pkg;

  // Widths of the payload fields and configuration registers.
  localparam int unsigned SampleW  = 10;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned FlagW    = 5;
  localparam int unsigned AvgW     = 19;
  localparam int unsigned VrefW    = 13;
  localparam int unsigned GainW    = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Scan geometry.
  localparam int unsigned Channels       = 5;
  localparam int unsigned TempChannels   = 3;
  localparam int unsigned SamplesDefault = 16;

  // Full scale of the converter is 1024 counts, so the millivolt scaling is a shift.
  localparam int unsigned FullScaleLog2 = 10;
  localparam int unsigned ProdW         = SampleW + VrefW;
  localparam int unsigned MvW           = ProdW - FullScaleLog2;

  // Temperature formula: (3500 - mv) / 22. The division is a multiply by
  // 2979 / 2^16, which is exact for magnitudes below 32768.
  localparam int unsigned TempOffset = 3500;
  localparam int unsigned TempRecip  = 2979;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned DiffW      = MvW + 2;
  localparam int unsigned MulBW      = 12;
  localparam int unsigned MulW       = MvW + MulBW;
  localparam int unsigned TempQW     = MulW - RecipShift;

  // Channel sums and their saturation.
  localparam int unsigned SumW   = 25;
  localparam int unsigned StepW  = $clog2(SumW);
  localparam int signed   AvgMax = 262143;

  // Channel codes.
  localparam logic [ChanW-1:0] CH_VOLT  = 3'd0;
  localparam logic [ChanW-1:0] CH_CURR  = 3'd1;
  localparam logic [ChanW-1:0] CH_TEMP1 = 3'd2;
  localparam logic [ChanW-1:0] CH_TEMP3 = 3'd4;

  // Request commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_VREF      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VOLT_LIM  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CURR_LIM  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TEMP1_LIM = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP2_LIM = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TEMP3_LIM = 3'd6;

  // Register reset values.
  localparam logic [VrefW-1:0]   VrefReset    = 13'd5000;
  localparam logic [GainW-1:0]   GainReset    = 6'd1;
  localparam logic [SampleW-1:0] HighLimReset = 10'd1023;
  localparam logic [SampleW-1:0] TempLimReset = 10'd0;

endpackage

>>> rtl/core/adc_scan_limit_check_averager_unit.sv
// Converter scan with limit checking and per-channel averaging, sums held in a small RAM.
`timescale 1ns / 1ps

// Conversion results are assigned in turn to voltage, current and three temperature
// channels; each channel keeps SAMPLES results and then spends one discarded slot while
// the multiplexer switches. Kept samples are limit checked (sticky fault flags, halt
// pulse), scaled to millivolts or temperature and added to a saturating signed sum held
// in a five-entry synchronous RAM. A kept sample passes through capture and scaling
// multiply, second multiply, read-modify-write of the sum and load of the output
// register; a discarded slot or a clear request goes straight to the output register.
// The discarded slot after temp3 ends the frame and produces five averages, channel 0
// first. After a read of the first sum, each average passes through sum magnitude,
// reciprocal multiply for the division by SAMPLES and load of the output register.
// A new request is taken once the previous one has placed its last result in the
// output register, even while that result still waits downstream.
module adc_scan_limit_check_averager_unit
  import aslca_pkg::*;
#(
  parameter int unsigned SAMPLES = SamplesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [SampleW-1:0]    sample_i,
  input  logic [FlagW-1:0]      clear_mask_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ChanW-1:0]      next_channel_o,
  output logic [FlagW-1:0]      fault_flags_o,
  output logic                  halt_o,
  output logic                  average_valid_o,
  output logic [ChanW-1:0]      average_channel_o,
  output logic signed [AvgW-1:0] average_value_o,
  output logic                  last_o,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(SAMPLES + 1);
  localparam logic [CntW-1:0] SampCnt  = CntW'(SAMPLES);

  // Division of a sum magnitude by SAMPLES as a multiply by a rounded-up reciprocal,
  // exact for every magnitude that fits the sum width.
  localparam int unsigned DivShift = SumW + $clog2(SAMPLES);
  localparam int unsigned DivMulW  = SumW + 1;
  localparam int unsigned DivProdW = SumW + DivMulW;
  localparam longint unsigned DivMulFull =
    ((64'd1 << DivShift) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [DivMulW-1:0] DivMul = DivMulW'(DivMulFull);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CONV    = 3'd1;
  localparam logic [2:0] S_ADD     = 3'd2;
  localparam logic [2:0] S_EMIT    = 3'd3;
  localparam logic [2:0] S_AVG_LD  = 3'd4;
  localparam logic [2:0] S_AVG_DIV = 3'd5;
  localparam logic [2:0] S_AVG_OUT = 3'd6;

  // Configuration registers.
  logic [VrefW-1:0]   vref_q;
  logic [GainW-1:0]   gain_q;
  logic [SampleW-1:0] volt_lim_q;
  logic [SampleW-1:0] curr_lim_q;
  logic [SampleW-1:0] temp_lim_q [TempChannels];

  // Control state.
  logic [2:0]          state_q, state_d;
  logic [ChanW-1:0]    ch_q, ch_d;
  logic [CntW-1:0]     slot_q, slot_d;
  logic [FlagW-1:0]    fault_q, fault_d;
  logic                halt_q, halt_d;
  logic [ChanW-1:0]    k_q, k_d;
  logic [Channels-1:0] ent_vld_q, ent_vld_d;
  logic                out_valid_q, out_valid_d;

  // Datapath registers.
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [MulW-1:0]     mul_q, mul_d;
  logic                neg_q, neg_d;
  logic                dneg_q, dneg_d;
  logic [SumW-1:0]     quo_q, quo_d;
  logic [ChanW-1:0]    o_nch_q, o_nch_d;
  logic [FlagW-1:0]    o_flt_q, o_flt_d;
  logic                o_halt_q, o_halt_d;
  logic                o_avld_q, o_avld_d;
  logic [ChanW-1:0]    o_ach_q, o_ach_d;
  logic [AvgW-1:0]     o_avg_q, o_avg_d;
  logic                o_last_q, o_last_d;

  // Sum memory.
  logic signed [SumW-1:0] sum_mem [Channels];
  logic signed [SumW-1:0] rd_q;
  logic                   rd_vld_q;
  logic                   mem_rd_en, mem_wr_en;
  logic [ChanW-1:0]       mem_rd_addr, mem_wr_addr;
  logic signed [SumW-1:0] mem_wr_data;

  // Combinational datapath.
  logic                   trip;
  logic [1:0]             tidx;
  logic [MvW-1:0]         mv;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]       diff_mag;
  logic [MvW-1:0]         mul_a;
  logic [MulBW-1:0]       mul_b;
  logic [TempQW-1:0]      temp_q;
  logic signed [SumW:0]   addend;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;
  logic signed [SumW-1:0] rd_val;
  logic [DivProdW-1:0]    div_prod;
  logic [AvgW-1:0]        avg_res;
  logic                   out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q        <= VrefReset;
      gain_q        <= GainReset;
      volt_lim_q    <= HighLimReset;
      curr_lim_q    <= HighLimReset;
      temp_lim_q[0] <= TempLimReset;
      temp_lim_q[1] <= TempLimReset;
      temp_lim_q[2] <= TempLimReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VREF:      vref_q        <= cfg_data_i[VrefW-1:0];
        REG_GAIN:      gain_q        <= cfg_data_i[GainW-1:0];
        REG_VOLT_LIM:  volt_lim_q    <= cfg_data_i[SampleW-1:0];
        REG_CURR_LIM:  curr_lim_q    <= cfg_data_i[SampleW-1:0];
        REG_TEMP1_LIM: temp_lim_q[0] <= cfg_data_i[SampleW-1:0];
        REG_TEMP2_LIM: temp_lim_q[1] <= cfg_data_i[SampleW-1:0];
        REG_TEMP3_LIM: temp_lim_q[2] <= cfg_data_i[SampleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Limit check on the incoming sample for the channel being scanned.
  assign tidx = 2'(ch_q - CH_TEMP1);
  always_comb begin
    case (ch_q)
      CH_VOLT: trip = (sample_i >= volt_lim_q);
      CH_CURR: trip = (sample_i >= curr_lim_q);
      default: trip = (sample_i <= temp_lim_q[tidx]);
    endcase
  end

  // Scaling: one multiplier serves the gain and the temperature reciprocal.
  assign mv       = prod_q[ProdW-1:FullScaleLog2];
  assign diff     = DiffW'(TempOffset) - $signed({2'b00, mv});
  assign diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign mul_a    = (ch_q == CH_VOLT || ch_q == CH_CURR) ? mv : diff_mag[MvW-1:0];
  always_comb begin
    case (ch_q)
      CH_VOLT: mul_b = MulBW'(gain_q);
      CH_CURR: mul_b = MulBW'(1);
      default: mul_b = MulBW'(TempRecip);
    endcase
  end

  // Accumulation with saturation to the signed sum width.
  assign temp_q = mul_q[MulW-1:RecipShift];
  always_comb begin
    if (ch_q == CH_VOLT || ch_q == CH_CURR) begin
      addend = $signed({1'b0, mul_q});
    end else if (neg_q) begin
      addend = -$signed({{(SumW + 1 - TempQW){1'b0}}, temp_q});
    end else begin
      addend = $signed({{(SumW + 1 - TempQW){1'b0}}, temp_q});
    end
  end
  assign rd_val   = rd_vld_q ? rd_q : '0;
  assign sum_wide = $signed({rd_val[SumW-1], rd_val}) + addend;
  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW - 1){1'b0}}} : {1'b0, {(SumW - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  // Quotient of the sum magnitude by the sample count.
  assign div_prod = DivProdW'(quo_q) * DivProdW'(DivMul);

  // Signed average with saturation to the output width.
  always_comb begin
    if (!dneg_q) begin
      avg_res = (quo_q > SumW'(AvgMax)) ? AvgW'(AvgMax) : quo_q[AvgW-1:0];
    end else if (quo_q > SumW'(AvgMax + 1)) begin
      avg_res = {1'b1, {(AvgW - 1){1'b0}}};
    end else begin
      avg_res = AvgW'(0) - quo_q[AvgW-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    slot_d      = slot_q;
    fault_d     = fault_q;
    halt_d      = halt_q;
    k_d         = k_q;
    ent_vld_d   = ent_vld_q;
    out_valid_d = out_valid_q;
    prod_d      = prod_q;
    mul_d       = mul_q;
    neg_d       = neg_q;
    dneg_d      = dneg_q;
    quo_d       = quo_q;
    o_nch_d     = o_nch_q;
    o_flt_d     = o_flt_q;
    o_halt_d    = o_halt_q;
    o_avld_d    = o_avld_q;
    o_ach_d     = o_ach_q;
    o_avg_d     = o_avg_q;
    o_last_d    = o_last_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ch_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ch_q;
    mem_wr_data = sum_sat;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          halt_d = 1'b0;
          if (cmd_i == CMD_CLEAR) begin
            fault_d = fault_q & ~clear_mask_i;
            state_d = S_EMIT;
          end else if (slot_q < SampCnt) begin
            if (trip) begin
              fault_d = fault_q | (FlagW'(1) << ch_q);
            end
            halt_d    = trip;
            prod_d    = ProdW'(sample_i) * ProdW'(vref_q);
            mem_rd_en = 1'b1;
            slot_d    = slot_q + CntW'(1);
            state_d   = S_CONV;
          end else begin
            slot_d = '0;
            if (ch_q == CH_TEMP3) begin
              // Frame end: fetch the first sum for averaging.
              ch_d        = CH_VOLT;
              k_d         = CH_VOLT;
              mem_rd_en   = 1'b1;
              mem_rd_addr = CH_VOLT;
              state_d     = S_AVG_LD;
            end else begin
              ch_d    = ch_q + ChanW'(1);
              state_d = S_EMIT;
            end
          end
        end
      end
      S_CONV: begin
        mul_d   = MulW'(mul_a) * MulW'(mul_b);
        neg_d   = diff[DiffW-1];
        state_d = S_ADD;
      end
      S_ADD: begin
        mem_wr_en       = 1'b1;
        ent_vld_d[ch_q] = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_nch_d     = ch_q;
          o_flt_d     = fault_q;
          o_halt_d    = halt_q;
          o_avld_d    = 1'b0;
          o_ach_d     = '0;
          o_avg_d     = '0;
          o_last_d    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_AVG_LD: begin
        dneg_d         = rd_val[SumW-1];
        quo_d          = rd_val[SumW-1] ? SumW'(-rd_val) : SumW'(rd_val);
        // The entry now reads as zero, which clears the sum for the next frame.
        ent_vld_d[k_q] = 1'b0;
        state_d        = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        quo_d   = SumW'(div_prod >> DivShift);
        state_d = S_AVG_OUT;
      end
      S_AVG_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_nch_d     = CH_VOLT;
          o_flt_d     = fault_q;
          o_halt_d    = 1'b0;
          o_avld_d    = 1'b1;
          o_ach_d     = k_q;
          o_avg_d     = avg_res;
          o_last_d    = (k_q == CH_TEMP3);
          if (k_q == CH_TEMP3) begin
            state_d = S_IDLE;
          end else begin
            k_d         = k_q + ChanW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = k_q + ChanW'(1);
            state_d     = S_AVG_LD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_VOLT;
      slot_q      <= '0;
      fault_q     <= '0;
      halt_q      <= 1'b0;
      k_q         <= CH_VOLT;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      slot_q      <= slot_d;
      fault_q     <= fault_d;
      halt_q      <= halt_d;
      k_q         <= k_d;
      ent_vld_q   <= ent_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mul_q    <= mul_d;
    neg_q    <= neg_d;
    dneg_q   <= dneg_d;
    quo_q    <= quo_d;
    o_nch_q  <= o_nch_d;
    o_flt_q  <= o_flt_d;
    o_halt_q <= o_halt_d;
    o_avld_q <= o_avld_d;
    o_ach_q  <= o_ach_d;
    o_avg_q  <= o_avg_d;
    o_last_q <= o_last_d;
  end

  // Sum RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      sum_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_q     <= sum_mem[mem_rd_addr];
      rd_vld_q <= ent_vld_q[mem_rd_addr];
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign next_channel_o    = o_nch_q;
  assign fault_flags_o     = o_flt_q;
  assign halt_o            = o_halt_q;
  assign average_valid_o   = o_avld_q;
  assign average_channel_o = o_ach_q;
  assign average_value_o   = $signed(o_avg_q);
  assign last_o            = o_last_q;

endmodule

>>> test/adc_scan_limit_check_averager_unit_tb.sv
// Self-checking testbench for the converter scan, limit check and averaging unit.
`timescale 1ns / 1ps

module adc_scan_limit_check_averager_unit_tb;
  import aslca_pkg::*;

  localparam int unsigned NumSamples = SamplesDefault;
  localparam longint SampleCount = NumSamples;
  localparam longint FullScale = longint'(1) << FullScaleLog2;
  localparam longint TempDivisor = 22;
  localparam longint SumHi = 16777215;
  localparam longint SumLo = -16777216;
  localparam longint AvgHi = 262143;
  localparam longint AvgLo = -262144;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles = 200;

  typedef struct {
    logic               cmd;
    logic [SampleW-1:0] sample;
    logic [FlagW-1:0]   mask;
  } scan_req_t;

  typedef struct {
    logic [ChanW-1:0]      next_ch;
    logic [FlagW-1:0]      flags;
    logic                  halt;
    logic                  avg_valid;
    logic [ChanW-1:0]      avg_ch;
    logic signed [AvgW-1:0] avg_value;
    logic                  last_flag;
  } scan_report_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = CMD_SAMPLE;
  logic [SampleW-1:0] sample = '0;
  logic [FlagW-1:0]   clear_mask = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ChanW-1:0]       next_channel;
  logic [FlagW-1:0]       fault_flags;
  logic                   halt;
  logic                   average_valid;
  logic [ChanW-1:0]       average_channel;
  logic signed [AvgW-1:0] average_value;
  logic                   last;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  adc_scan_limit_check_averager_unit #(
    .SAMPLES(NumSamples)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .sample_i         (sample),
    .clear_mask_i     (clear_mask),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .next_channel_o   (next_channel),
    .fault_flags_o    (fault_flags),
    .halt_o           (halt),
    .average_valid_o  (average_valid),
    .average_channel_o(average_channel),
    .average_value_o  (average_value),
    .last_o           (last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic [VrefW-1:0]   vref_mv = VrefReset;
  logic [GainW-1:0]   volt_gain = GainReset;
  logic [SampleW-1:0] volt_lim = HighLimReset;
  logic [SampleW-1:0] curr_lim = HighLimReset;
  logic [SampleW-1:0] temp_lim [TempChannels];

  // Scan state as the block should hold it.
  logic [ChanW-1:0] scan_ch = CH_VOLT;
  int               slot_cnt = 0;
  longint           chan_sum [Channels];
  logic [FlagW-1:0] flag_bits = '0;

  scan_req_t    conversion_q [$];
  scan_report_t predicted_reports [$];

  int  err_count = 0;
  int  driven_count = 0;
  int  taken_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  long_hold_left = 0;
  int  hold_orders = 0;
  int  holds_done = 0;
  bit  idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint to_channel_units(logic [ChanW-1:0] ch, logic [SampleW-1:0] raw);
    longint mv;
    mv = (longint'(raw) * longint'(vref_mv)) / FullScale;
    if (ch == CH_VOLT) return mv * longint'(volt_gain);
    if (ch == CH_CURR) return mv;
    return (longint'(TempOffset) - mv) / TempDivisor;
  endfunction

  function automatic void push_report(logic [ChanW-1:0] nch, logic hlt, logic vld,
                                      logic [ChanW-1:0] ach, longint avg, logic lst);
    scan_report_t r;
    r.next_ch   = nch;
    r.flags     = flag_bits;
    r.halt      = hlt;
    r.avg_valid = vld;
    r.avg_ch    = ach;
    r.avg_value = avg[AvgW-1:0];
    r.last_flag = lst;
    predicted_reports.push_back(r);
  endfunction

  // Advances the scan by one request and queues the reports it should produce.
  function automatic void predict_scan_step(scan_req_t rq);
    bit     trip;
    longint avg;
    if (rq.cmd == CMD_CLEAR) begin
      flag_bits = flag_bits & ~rq.mask;
      push_report(scan_ch, 1'b0, 1'b0, CH_VOLT, 0, 1'b1);
    end else if (slot_cnt < NumSamples) begin
      if (scan_ch == CH_VOLT) trip = rq.sample >= volt_lim;
      else if (scan_ch == CH_CURR) trip = rq.sample >= curr_lim;
      else trip = rq.sample <= temp_lim[scan_ch - CH_TEMP1];
      if (trip) flag_bits[scan_ch] = 1'b1;
      chan_sum[scan_ch] = clamp_to(chan_sum[scan_ch] + to_channel_units(scan_ch, rq.sample),
                                   SumLo, SumHi);
      slot_cnt++;
      push_report(scan_ch, trip, 1'b0, CH_VOLT, 0, 1'b1);
    end else begin
      slot_cnt = 0;
      if (scan_ch != CH_TEMP3) begin
        scan_ch = scan_ch + 1'b1;
        push_report(scan_ch, 1'b0, 1'b0, CH_VOLT, 0, 1'b1);
      end else begin
        // The discarded slot after temp3 closes the frame with one average per channel.
        scan_ch = CH_VOLT;
        for (int k = 0; k < Channels; k++) begin
          avg = clamp_to(chan_sum[k] / SampleCount, AvgLo, AvgHi);
          chan_sum[k] = 0;
          push_report(CH_VOLT, 1'b0, 1'b1, ChanW'(k), avg, k == Channels - 1);
        end
      end
    end
  endfunction

  function automatic int pick_gap(int quiet_pct);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < quiet_pct) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void queue_req(logic c, logic [SampleW-1:0] s, logic [FlagW-1:0] m);
    scan_req_t rq;
    rq.cmd    = c;
    rq.sample = s;
    rq.mask   = m;
    conversion_q.push_back(rq);
  endfunction

  // Random requests lean on the rails and on values right around the trip points.
  function automatic void queue_random_reqs(int n);
    logic [SampleW-1:0] lims [Channels];
    logic [SampleW-1:0] s;
    int                 r;
    int                 near;
    lims[0] = volt_lim;
    lims[1] = curr_lim;
    for (int t = 0; t < TempChannels; t++) lims[t + 2] = temp_lim[t];
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 12) s = '0;
      else if (r < 24) s = '1;
      else if (r < 50) begin
        near = int'(lims[$urandom_range(Channels - 1)]) + $urandom_range(4) - 2;
        s = SampleW'(clamp_to(near, 0, 1023));
      end else s = SampleW'($urandom_range(1023));
      queue_req(($urandom_range(99) < 6) ? CMD_CLEAR : CMD_SAMPLE, s,
                FlagW'($urandom_range(31)));
    end
  endfunction

  // Request driver.
  always @(negedge clk_i) begin : drive_requests
    scan_req_t rq;
    if (rst_ni && (!in_valid || taken_count == driven_count)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (conversion_q.size() > 0) begin
        rq = conversion_q.pop_front();
        cmd        <= rq.cmd;
        sample     <= rq.sample;
        clear_mask <= rq.mask;
        in_valid   <= 1'b1;
        driven_count++;
        gap_left = pick_gap(55);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : take_requests
    scan_req_t rq;
    if (rst_ni && in_valid && !in_stall) begin
      rq.cmd    = cmd;
      rq.sample = sample;
      rq.mask   = clear_mask;
      predict_scan_step(rq);
      taken_count++;
    end
  end

  // Receiver back-pressure, with one long hold-off when asked for.
  always @(negedge clk_i) begin : drive_stall
    logic hold;
    int   n;
    hold = 1'b0;
    if (rst_ni) begin
      if (hold_orders != holds_done) begin
        holds_done = hold_orders;
        long_hold_left = LongHoldCycles;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        hold = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        hold = 1'b1;
      end else begin
        n = pick_gap(65);
        if (n > 0) begin
          stall_left = n - 1;
          hold = 1'b1;
        end
      end
    end
    out_stall <= hold;
  end

  function automatic int field_bad(string name, longint want, longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i) begin : check_reports
    scan_report_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual channel %0d",
                 $time, next_channel);
        err_count++;
      end else begin
        want = predicted_reports.pop_front();
        err_count += field_bad("next_channel", want.next_ch, next_channel);
        err_count += field_bad("fault_flags", want.flags, fault_flags);
        err_count += field_bad("halt", want.halt, halt);
        err_count += field_bad("average_valid", want.avg_valid, average_valid);
        err_count += field_bad("average_channel", want.avg_ch, average_channel);
        err_count += field_bad("average_value", want.avg_value, average_value);
        err_count += field_bad("last", want.last_flag, last);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_VREF:      vref_mv = data[VrefW-1:0];
      REG_GAIN:      volt_gain = data[GainW-1:0];
      REG_VOLT_LIM:  volt_lim = data[SampleW-1:0];
      REG_CURR_LIM:  curr_lim = data[SampleW-1:0];
      REG_TEMP1_LIM: temp_lim[0] = data[SampleW-1:0];
      REG_TEMP2_LIM: temp_lim[1] = data[SampleW-1:0];
      REG_TEMP3_LIM: temp_lim[2] = data[SampleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int vr, int gn, int vl, int cl, int t1, int t2, int t3);
    write_reg(REG_VREF, CfgDataW'(vr));
    write_reg(REG_GAIN, CfgDataW'(gn));
    write_reg(REG_VOLT_LIM, CfgDataW'(vl));
    write_reg(REG_CURR_LIM, CfgDataW'(cl));
    write_reg(REG_TEMP1_LIM, CfgDataW'(t1));
    write_reg(REG_TEMP2_LIM, CfgDataW'(t2));
    write_reg(REG_TEMP3_LIM, CfgDataW'(t3));
  endtask

  // Returns once every queued request has been taken and every report has arrived.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (conversion_q.size() > 0 || in_valid || predicted_reports.size() > 0);
  endtask

  initial begin
    for (int k = 0; k < Channels; k++) chan_sum[k] = 0;
    for (int t = 0; t < TempChannels; t++) temp_lim[t] = TempLimReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: the rails, the clear command and masks on the voltage channel.
    queue_req(CMD_SAMPLE, 10'd0, 5'd0);
    queue_req(CMD_SAMPLE, 10'd1023, 5'd31);
    queue_req(CMD_CLEAR, 10'd1023, 5'd0);
    queue_req(CMD_CLEAR, 10'd0, 5'd31);
    queue_req(CMD_SAMPLE, 10'd1022, 5'd21);
    queue_req(CMD_SAMPLE, 10'd1023, 5'd10);
    queue_req(CMD_CLEAR, 10'd682, 5'd30);
    queue_req(CMD_CLEAR, 10'd341, 5'd1);
    queue_req(CMD_SAMPLE, 10'd341, 5'd0);
    queue_req(CMD_SAMPLE, 10'd682, 5'd31);
    queue_req(CMD_SAMPLE, 10'd1, 5'd0);
    queue_req(CMD_SAMPLE, 10'd512, 5'd0);
    queue_random_reqs(70);
    wait_quiet();

    // Upper extremes, every channel but current always tripping, no idling on either side.
    idle_on = 1'b0;
    set_config(5500, 32, 0, 1023, 1023, 1023, 1023);
    queue_random_reqs(75);
    wait_quiet();

    // Lower extremes; an out-of-range index and spare data bits must be dropped.
    idle_on = 1'b1;
    set_config(1, 1, 1023, 0, 0, 0, 0);
    write_reg(RegUnused, 13'h1FFF);
    write_reg(REG_TEMP1_LIM, 13'h1C05);
    queue_random_reqs(75);
    wait_quiet();

    // Random settings; the receiver holds off long enough for the input to back up.
    set_config($urandom_range(5500, 1), $urandom_range(32, 1), $urandom_range(1023),
               $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
               $urandom_range(1023));
    queue_random_reqs(80);
    hold_orders++;
    wait_quiet();

    set_config($urandom_range(5500, 1), $urandom_range(32, 1), $urandom_range(1023),
               $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
               $urandom_range(1023));
    queue_random_reqs(80);
    wait_quiet();

    set_config(5000, 1, 1023, 1023, 0, 0, 0);
    queue_random_reqs(75);
    wait_quiet();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && predicted_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #9_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/aslca_pkg.sv
rtl/core/adc_scan_limit_check_averager_unit.sv
test/adc_scan_limit_check_averager_unit_tb.sv
